// File: rtl/ncsf_pkg.sv
// Shared types and constants of the time-sync sample filter.
// No dependencies; every other file of the block but ncsf_mul imports this package.
`timescale 1ns / 1ps

package ncsf_pkg;

    // Ring depth and widths that follow from it.
    localparam int STAGES   = 8;
    localparam int SLOT_W   = $clog2(STAGES);
    localparam int COUNT_W  = $clog2(STAGES + 1);
    localparam int DIV_W    = $clog2(STAGES);

    // Field widths.
    localparam int OFF_W    = 48;
    localparam int DLY_W    = 47;
    localparam int DSP_W    = 37;
    localparam int SEC_W    = 32;
    localparam int DIST_W   = 48;
    localparam int JIT_W    = 47;

    // Sum of squared offset spreads; kept even for the two-bit root steps.
    localparam int SUM_W    = 2 * ((97 + $clog2(STAGES)) / 2);
    localparam int ROOT_W   = SUM_W / 2;

    // Sixteen seconds in Q5.32, the dispersion ceiling.
    localparam logic [DSP_W-1:0] MAX_DISP = DSP_W'(64'd16 << 32);
    localparam logic [JIT_W-1:0] JIT_MAX  = {JIT_W{1'b1}};

    // Configuration register indexes.
    localparam logic [2:0] REG_RATE      = 3'd0;
    localparam logic [2:0] REG_ALLAN     = 3'd1;
    localparam logic [2:0] REG_MAX_DIST  = 3'd2;
    localparam logic [2:0] REG_PRECISION = 3'd3;
    localparam logic [2:0] REG_POLL      = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_NONE   = 2'd1;
    localparam logic [1:0] ST_SPIKE  = 2'd2;
    localparam logic [1:0] ST_OLD    = 2'd3;

    // Next ring slot with wraparound.
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(STAGES - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

// File: rtl/ncsf_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
// Depends on nothing; used by the sequencer for aging and offset squares.
`timescale 1ns / 1ps

module ncsf_mul (
    input  logic        aclk,
    input  logic [31:0] mul_a,
    input  logic [31:0] mul_b,
    output logic [63:0] prod_reg
);

    // One product per cycle, available in the next cycle.
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

endmodule

// File: rtl/ncsf_root.sv
// Iterative unit: bit-serial division by a small count, then a digit-by-digit
// integer square root of the quotient. Depends on ncsf_pkg.
`timescale 1ns / 1ps

module ncsf_root (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ncsf_pkg::SUM_W-1:0]  dividend,
    input  logic [ncsf_pkg::DIV_W-1:0]  divisor,
    output logic                        done_reg,
    output logic [ncsf_pkg::ROOT_W-1:0] root_reg
);
    import ncsf_pkg::*;

    typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_t;

    localparam int CNT_W = $clog2(SUM_W + 1);

    rstate_t            state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   val_reg;
    logic [DIV_W-1:0]   den_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [ROOT_W+1:0]  srem_reg;

    logic [DIV_W:0]     r2;
    logic               ge;
    logic [ROOT_W+3:0]  sr2;
    logic [ROOT_W+3:0]  trial;
    logic               sge;

    // One quotient bit or one root bit per cycle.
    always_comb begin
        r2    = {rem_reg, val_reg[SUM_W-1]};
        ge    = r2 >= {1'b0, den_reg};
        sr2   = {srem_reg, val_reg[SUM_W-1:SUM_W-2]};
        trial = {2'b00, root_reg, 2'b01};
        sge   = sr2 >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                R_IDLE: begin
                    if (start) begin
                        val_reg   <= dividend;
                        den_reg   <= divisor;
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(SUM_W - 1);
                        state_reg <= R_DIV;
                    end
                end
                R_DIV: begin
                    rem_reg <= ge ? DIV_W'(r2 - {1'b0, den_reg}) : DIV_W'(r2);
                    val_reg <= {val_reg[SUM_W-2:0], ge};
                    if (cnt_reg == '0) begin
                        cnt_reg   <= CNT_W'(ROOT_W - 1);
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        state_reg <= R_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                R_SQRT: begin
                    srem_reg <= sge ? (ROOT_W+2)'(sr2 - trial) : (ROOT_W+2)'(sr2);
                    root_reg <= {root_reg[ROOT_W-2:0], sge};
                    val_reg  <= {val_reg[SUM_W-3:0], 2'b00};
                    if (cnt_reg == '0) begin
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/ntp_clock_sample_filter.sv
// Top level of the time-sync sample filter: ring storage, sequencer, output register.
// Depends on ncsf_pkg, ncsf_mul and ncsf_root.
`timescale 1ns / 1ps

// One sample request is taken at a time; s_tready is high only while the
// sequencer is idle. The time a sample takes grows with its number of survivors
// and is set by the single shared multiplier (three partial squares and one
// final fold per survivor), by the one-read-port exchange sort of the eight
// distances and by the bit-serial unit that divides the 100-bit square sum and
// takes its root. A finished result waits in the output register while the next
// sample request is accepted. Reset clears the ring at once; no clearing pass.
module ntp_clock_sample_filter (
    input  logic         aclk,
    input  logic         aresetn,
    // Sample input.
    input  logic         s_tvalid,
    output logic         s_tready,
    // [47:0] sample_offset_in, [94:48] sample_delay_in,
    // [131:95] sample_dispersion_in, [163:132] now_seconds, [167:164] zero
    input  logic [167:0] s_tdata,
    // Result output.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [47:0] filtered_offset, [94:48] filtered_delay, [131:95] filtered_dispersion,
    // [178:132] filtered_jitter, [182:179] survivor_count, [185:183] best_slot,
    // [191:186] zero
    output logic [191:0] m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser,
    // Configuration writes.
    input  logic         s_cfg_valid,
    output logic         s_cfg_ready,
    input  logic [2:0]   s_cfg_index,
    input  logic [36:0]  s_cfg_data
);
    import ncsf_pkg::*;

    typedef enum logic [3:0] {
        IDLE, DT, AGE, SORT_LOAD, SORT_CMP, SORT_STORE, PRUNE, LOAD_BEST,
        SUM_RD, SQ_LO, SQ_MID, SQ_HI, SQ_ADD, EVAL, ROOT_WAIT, FINAL
    } state_t;

    // Configuration registers.
    logic [22:0]        rate_reg;
    logic [4:0]         allan_reg;
    logic [DSP_W-1:0]   maxd_reg;
    logic signed [5:0]  prec_reg;
    logic [4:0]         poll_reg;

    // Ring and persistent state.
    logic signed [OFF_W-1:0] off_reg [STAGES];
    logic [DLY_W-1:0]   dly_reg [STAGES];
    logic [DSP_W-1:0]   dsp_reg [STAGES];
    logic [SEC_W-1:0]   epo_reg [STAGES];
    logic [SLOT_W-1:0]  ws_reg;
    logic [SEC_W-1:0]   last_upd_reg;
    logic [SEC_W-1:0]   last_used_reg;
    logic signed [OFF_W-1:0] held_reg;

    // Working state of one sample.
    state_t             state_reg;
    logic [DIST_W-1:0]  dst_reg [STAGES];
    logic [SLOT_W-1:0]  ord_reg [STAGES];
    logic [SEC_W-1:0]   now_reg;
    logic [DSP_W-1:0]   dtemp_reg;
    logic [SLOT_W-1:0]  idx_reg;
    logic [SLOT_W-1:0]  q_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [DIST_W-1:0]  cur_dst_reg;
    logic [SLOT_W-1:0]  cur_ord_reg;
    logic [COUNT_W-1:0] m_reg;
    logic [SLOT_W-1:0]  k_reg;
    logic signed [OFF_W-1:0] best_off_reg;
    logic [DLY_W-1:0]   best_dly_reg;
    logic [DSP_W-1:0]   best_dsp_reg;
    logic [SEC_W-1:0]   best_epo_reg;
    logic [DSP_W-1:0]   dsum_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [OFF_W-1:0]   t_reg;
    logic [OFF_W-1:0]   etemp_reg;

    // Output register.
    logic               m_valid_reg;
    logic [191:0]       m_data_reg;
    logic [1:0]         m_user_reg;

    // Shared units.
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod_reg;
    logic               root_start;
    logic               root_done_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [DIV_W-1:0]   root_div;

    // Combinational helpers.
    logic [SLOT_W-1:0]  pos_sel;
    logic [SLOT_W-1:0]  slot_sel;
    logic [DSP_W:0]     dnew;
    logic [SEC_W-1:0]   age;
    logic [DIST_W-1:0]  slot_dist;
    logic               survive;
    logic signed [OFF_W:0] odiff;
    logic [OFF_W-1:0]   tabs;
    logic signed [OFF_W:0] hdiff;
    logic [DSP_W:0]     dsum_add;
    logic [6:0]         flr_amt;
    logic [63:0]        flr;
    logic [63:0]        jit64;
    logic [JIT_W-1:0]   jit;
    logic [JIT_W+1:0]   jit3;
    logic [SEC_W-1:0]   epo_diff;
    logic               spike;
    logic               out_free;
    logic               out_load;
    logic               last_idx;
    logic [SEC_W-1:0]   elapsed;

    assign s_tready    = (state_reg == IDLE);
    assign s_cfg_ready = (state_reg == IDLE);
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;
    assign m_tuser     = m_user_reg;
    assign out_free    = !m_valid_reg || m_tready;
    assign out_load    = out_free &&
                         ((state_reg == EVAL && m_reg == '0) || state_reg == FINAL);

    ncsf_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    ncsf_root u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .dividend (sum_reg),
        .divisor  (root_div),
        .done_reg (root_done_reg),
        .root_reg (root_reg)
    );

    // Read addresses of the ring and of the distance list.
    always_comb begin
        pos_sel = (state_reg == SORT_CMP) ? q_reg : idx_reg;
        unique case (state_reg)
            LOAD_BEST: slot_sel = ord_reg[0];
            SUM_RD:    slot_sel = ord_reg[pos_sel];
            default:   slot_sel = slot_reg;
        endcase
    end

    // Multiplier operands: aging rate on acceptance, partial squares later.
    always_comb begin
        elapsed = s_tdata[163:132] - last_upd_reg;
        unique case (state_reg)
            IDLE:    begin mul_a = {9'd0, rate_reg};       mul_b = elapsed;      end
            SQ_LO:   begin mul_a = t_reg[31:0];            mul_b = t_reg[31:0];  end
            SQ_MID:  begin mul_a = {16'd0, t_reg[47:32]};  mul_b = t_reg[31:0];  end
            SQ_HI:   begin mul_a = {16'd0, t_reg[47:32]};  mul_b = {16'd0, t_reg[47:32]}; end
            default: begin mul_a = '0;                     mul_b = '0;           end
        endcase
    end

    // Aging, distance, pruning, dispersion sum and offset spreads of the slot under the sequencer.
    always_comb begin
        dnew = {1'b0, dsp_reg[slot_sel]} + ((idx_reg != '0) ? {1'b0, dtemp_reg} : '0);
        age  = now_reg - epo_reg[slot_sel];
        if (dnew >= {1'b0, MAX_DISP}) begin
            slot_dist = DIST_W'(MAX_DISP);
        end else if ({1'b0, age} > (33'd1 << allan_reg)) begin
            slot_dist = DIST_W'(dly_reg[slot_sel]) + DIST_W'(dnew);
        end else begin
            slot_dist = DIST_W'(dly_reg[slot_sel]);
        end
        survive = !(dst_reg[pos_sel] >= DIST_W'(MAX_DISP) ||
                    (m_reg >= COUNT_W'(2) && dst_reg[pos_sel] >= DIST_W'(maxd_reg)));
        last_idx = (idx_reg == '0);
        dsum_add = {1'b0, dsum_reg} + {1'b0, dsp_reg[slot_sel]};
        odiff = {off_reg[slot_sel][OFF_W-1], off_reg[slot_sel]} -
                {best_off_reg[OFF_W-1], best_off_reg};
        tabs  = odiff[OFF_W] ? OFF_W'(-odiff) : OFF_W'(odiff);
        hdiff = {held_reg[OFF_W-1], held_reg} - {best_off_reg[OFF_W-1], best_off_reg};
    end

    // Jitter floor, saturation, the spike test and the root unit controls.
    always_comb begin
        flr_amt  = 7'd32 + {prec_reg[5], prec_reg};
        flr      = 64'd1 << flr_amt[5:0];
        jit64    = (64'(root_reg) < flr) ? flr : 64'(root_reg);
        jit      = (jit64 > 64'(JIT_MAX)) ? JIT_MAX : jit64[JIT_W-1:0];
        jit3     = {2'b00, jit} + {1'b0, jit, 1'b0};
        epo_diff = best_epo_reg - last_used_reg;
        spike    = (dsum_reg < maxd_reg) && (best_dsp_reg < maxd_reg) &&
                   ({1'b0, etemp_reg} > jit3) &&
                   ({2'b00, epo_diff} < (34'd2 << poll_reg));
        root_start = (state_reg == EVAL) && (m_reg != '0) && out_free;
        root_div   = (m_reg > COUNT_W'(1)) ? DIV_W'(m_reg - 1'b1) : DIV_W'(1);
    end

    // Sequencer, ring state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            m_valid_reg   <= 1'b0;
            ws_reg        <= '0;
            last_upd_reg  <= '0;
            last_used_reg <= '0;
            held_reg      <= '0;
            rate_reg      <= 23'd64425;
            allan_reg     <= 5'd11;
            maxd_reg      <= DSP_W'(64'd6442450944);
            prec_reg      <= -6'sd10;
            poll_reg      <= 5'd0;
            for (int s = 0; s < STAGES; s++) begin
                off_reg[s] <= '0;
                dly_reg[s] <= '0;
                dsp_reg[s] <= '0;
                epo_reg[s] <= '0;
            end
        end else begin
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end

            // Register writes.
            if (s_cfg_valid && s_cfg_ready) begin
                unique case (s_cfg_index)
                    REG_RATE:      rate_reg  <= s_cfg_data[22:0];
                    REG_ALLAN:     allan_reg <= s_cfg_data[4:0];
                    REG_MAX_DIST:  maxd_reg  <= s_cfg_data;
                    REG_PRECISION: prec_reg  <= s_cfg_data[5:0];
                    REG_POLL:      poll_reg  <= s_cfg_data[4:0];
                    default:       ;
                endcase
            end

            unique case (state_reg)
                IDLE: begin
                    if (s_tvalid) begin
                        off_reg[ws_reg] <= s_tdata[47:0];
                        dly_reg[ws_reg] <= s_tdata[94:48];
                        dsp_reg[ws_reg] <= (s_tdata[131:95] > MAX_DISP) ?
                                           MAX_DISP : s_tdata[131:95];
                        epo_reg[ws_reg] <= s_tdata[163:132];
                        now_reg         <= s_tdata[163:132];
                        last_upd_reg    <= s_tdata[163:132];
                        ws_reg          <= slot_inc(ws_reg);
                        slot_reg        <= slot_inc(ws_reg);
                        idx_reg         <= SLOT_W'(STAGES - 1);
                        state_reg       <= DT;
                    end
                end
                DT: begin
                    dtemp_reg <= (prod_reg > 64'(MAX_DISP)) ? MAX_DISP : prod_reg[DSP_W-1:0];
                    state_reg <= AGE;
                end
                // Oldest slot first; the newest slot is not aged.
                AGE: begin
                    dsp_reg[slot_sel] <= (dnew >= {1'b0, MAX_DISP}) ? MAX_DISP :
                                         dnew[DSP_W-1:0];
                    dst_reg[idx_reg]  <= slot_dist;
                    ord_reg[idx_reg]  <= slot_sel;
                    slot_reg          <= slot_inc(slot_reg);
                    if (last_idx) begin
                        idx_reg   <= SLOT_W'(1);
                        state_reg <= SORT_LOAD;
                    end else begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                // Exchange sort; the element at idx travels in cur.
                SORT_LOAD: begin
                    cur_dst_reg <= dst_reg[pos_sel];
                    cur_ord_reg <= ord_reg[pos_sel];
                    q_reg       <= '0;
                    state_reg   <= SORT_CMP;
                end
                SORT_CMP: begin
                    if (dst_reg[pos_sel] > cur_dst_reg) begin
                        dst_reg[pos_sel] <= cur_dst_reg;
                        ord_reg[pos_sel] <= cur_ord_reg;
                        cur_dst_reg      <= dst_reg[pos_sel];
                        cur_ord_reg      <= ord_reg[pos_sel];
                    end
                    if (q_reg == idx_reg - 1'b1) begin
                        state_reg <= SORT_STORE;
                    end else begin
                        q_reg <= q_reg + 1'b1;
                    end
                end
                SORT_STORE: begin
                    dst_reg[idx_reg] <= cur_dst_reg;
                    ord_reg[idx_reg] <= cur_ord_reg;
                    if (idx_reg == SLOT_W'(STAGES - 1)) begin
                        idx_reg   <= '0;
                        m_reg     <= '0;
                        state_reg <= PRUNE;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= SORT_LOAD;
                    end
                end
                PRUNE: begin
                    if (survive) begin
                        m_reg <= m_reg + 1'b1;
                    end
                    if (idx_reg == SLOT_W'(STAGES - 1)) begin
                        state_reg <= LOAD_BEST;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                LOAD_BEST: begin
                    k_reg        <= slot_sel;
                    best_off_reg <= off_reg[slot_sel];
                    best_dly_reg <= dly_reg[slot_sel];
                    best_dsp_reg <= dsp_reg[slot_sel];
                    best_epo_reg <= epo_reg[slot_sel];
                    dsum_reg     <= '0;
                    sum_reg      <= '0;
                    idx_reg      <= SLOT_W'(STAGES - 1);
                    state_reg    <= SUM_RD;
                end
                // Worst-ranked slot first: halving sum and squared spreads.
                SUM_RD: begin
                    dsum_reg <= dsum_add[DSP_W:1];
                    t_reg    <= tabs;
                    if (COUNT_W'(idx_reg) < m_reg) begin
                        state_reg <= SQ_LO;
                    end else if (last_idx) begin
                        state_reg <= EVAL;
                    end else begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                SQ_LO: begin
                    state_reg <= SQ_MID;
                end
                SQ_MID: begin
                    sum_reg   <= sum_reg + SUM_W'(prod_reg);
                    state_reg <= SQ_HI;
                end
                SQ_HI: begin
                    sum_reg   <= sum_reg + (SUM_W'(prod_reg) << 33);
                    state_reg <= SQ_ADD;
                end
                // Fold in the high square, then move on to the next better slot.
                SQ_ADD: begin
                    sum_reg <= sum_reg + (SUM_W'(prod_reg) << 64);
                    if (last_idx) begin
                        state_reg <= EVAL;
                    end else begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= SUM_RD;
                    end
                end
                EVAL: begin
                    if (out_free) begin
                        if (m_reg == '0) begin
                            m_data_reg  <= {6'd0, k_reg, m_reg, {JIT_W{1'b0}}, dsum_reg,
                                            {DLY_W{1'b0}}, {OFF_W{1'b0}}};
                            m_user_reg  <= ST_NONE;
                            m_valid_reg <= 1'b1;
                            state_reg   <= IDLE;
                        end else begin
                            etemp_reg <= hdiff[OFF_W] ? OFF_W'(-hdiff) : OFF_W'(hdiff);
                            held_reg  <= best_off_reg;
                            state_reg <= ROOT_WAIT;
                        end
                    end
                end
                ROOT_WAIT: begin
                    if (root_done_reg) begin
                        state_reg <= FINAL;
                    end
                end
                FINAL: begin
                    if (out_free) begin
                        m_data_reg  <= {6'd0, k_reg, m_reg, jit, dsum_reg,
                                        best_dly_reg, best_off_reg};
                        m_valid_reg <= 1'b1;
                        if (spike) begin
                            m_user_reg <= ST_SPIKE;
                        end else if (best_epo_reg <= last_used_reg) begin
                            m_user_reg <= ST_OLD;
                        end else begin
                            m_user_reg    <= ST_ACCEPT;
                            last_used_reg <= best_epo_reg;
                        end
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

// File: rtl/ncsf_checker.sv
// Port-level checks of the time-sync sample filter, bound to its top level.
// Depends on ncsf_pkg and ntp_clock_sample_filter.
`timescale 1ns / 1ps

module ncsf_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic [1:0]   m_tuser
);
    import ncsf_pkg::*;

    // A sample request keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again right after a sample request");

    // A waiting result holds until taken.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("pending result changed");

    // No survivors exactly when the status says so.
    a_none_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == ST_NONE) == (m_tdata[182:179] == 4'd0)))
        else $error("status and survivor count disagree");

    // Survivor count never exceeds the ring depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[182:179] <= 4'(STAGES)))
        else $error("survivor count beyond ring depth");

    // With survivors the jitter is nonzero, as it is held at least at its nonzero floor.
    a_jitter_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_NONE) |-> (m_tdata[178:132] != '0))
        else $error("zero jitter with survivors");

endmodule

bind ntp_clock_sample_filter ncsf_checker u_ncsf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
